/* rtl/bds_pkg.sv */
`timescale 1ns / 1ps

package bds_pkg;

  localparam int BDS_MAX_ROW_WIDTH = 1024;
  localparam int MAX_FRAME_HEIGHT  = 1024;

  localparam int SAMPLE_W  = 16;
  localparam int PAIR_W    = 17;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 4;
  localparam int ROW_CNT_W = 10;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] ROW_WIDTH_RESET    = CFG_W'(1024);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(1024);

  // Work handed from the front to the back.
  typedef enum logic {
    OP_STORE = 1'b0,
    OP_EMIT  = 1'b1
  } bds_op_t;

  typedef struct packed {
    bds_op_t             op;
    logic [PAIR_W-1:0]   pair;
    logic                eor;
    logic                eof;
  } bds_item_t;

endpackage

/* rtl/bds_if.sv */
`timescale 1ns / 1ps

interface bds_in_if;
  logic                          valid;
  logic                          ready;
  logic [bds_pkg::SAMPLE_W-1:0]  sample;
  logic                          first_of_frame;

  modport source (output valid, output sample, output first_of_frame, input ready);
  modport sink   (input valid, input sample, input first_of_frame, output ready);
endinterface

interface bds_out_if;
  logic                          valid;
  logic                          ready;
  logic [bds_pkg::SAMPLE_W-1:0]  average;
  logic                          last_of_row;
  logic                          last_of_frame;

  modport source (output valid, output average, output last_of_row, output last_of_frame,
                  input ready);
  modport sink   (input valid, input average, input last_of_row, input last_of_frame,
                  output ready);
endinterface

interface bds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bds_pkg::CFG_IDX_W-1:0]  index;
  logic [bds_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/box_downsample_2x2_top.sv */
`timescale 1ns / 1ps

// Channel   Dir   Word                                   Accepted when
// in_ch     in    sample[15:0], first_of_frame           valid && ready
// out_ch    out   average[15:0], last_of_row, last_of_frame  valid && ready
// cfg_ch    in    index[3:0], data[10:0]                 valid && ready (ready is always 1)
//
// One sample is taken every clock while the queue has room; a block average
// leaves by way of the queue, the line store read and the output register.
// rst_n is synchronous; it clears the counters, the queue and the valid flags.
// The line store has no clearing pass and is ready as soon as reset ends.
// A stalled output backs up through the two-entry queue before in_ch.ready drops.
module box_downsample_2x2_top #(
  parameter int MAX_ROW_WIDTH = bds_pkg::BDS_MAX_ROW_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  bds_in_if.sink     in_ch,
  bds_out_if.source  out_ch,
  bds_cfg_if.sink    cfg_ch
);
  import bds_pkg::*;

  localparam int SW = $clog2(MAX_ROW_WIDTH / 2);
  localparam int QW = SW + $bits(bds_item_t);

  logic            push_valid, push_ready;
  bds_item_t       push_item;
  logic [SW-1:0]   push_slot;

  logic            pop_valid, pop_ready;
  logic [QW-1:0]   pop_data;
  bds_item_t       pop_item;
  logic [SW-1:0]   pop_slot;

  bds_front #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .SW            (SW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .push_slot  (push_slot)
  );

  bds_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_slot, push_item}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_slot = pop_data[QW-1:QW-SW];
  assign pop_item = pop_data[QW-SW-1:0];

  bds_back #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .SW            (SW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .pop_slot  (pop_slot),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/bds_ram.sv */
`timescale 1ns / 1ps

module bds_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

/* rtl/bds_front.sv */
`timescale 1ns / 1ps

module bds_front #(
  parameter int MAX_ROW_WIDTH = bds_pkg::BDS_MAX_ROW_WIDTH,
  parameter int SW            = $clog2(MAX_ROW_WIDTH / 2)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bds_in_if.sink               in_ch,
  bds_cfg_if.sink              cfg_ch,
  output logic                 push_valid,
  input  logic                 push_ready,
  output bds_pkg::bds_item_t   push_item,
  output logic [SW-1:0]        push_slot
);
  import bds_pkg::*;

  localparam int CW  = $clog2(MAX_ROW_WIDTH + 1);
  localparam int CLW = $clog2(MAX_ROW_WIDTH);
  localparam int WW  = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [WW-1:0]    MAX_W = WW'(MAX_ROW_WIDTH);
  localparam logic [CFG_W-1:0] MAX_H = CFG_W'(MAX_FRAME_HEIGHT);

  logic [CFG_W-1:0]     row_width_r;
  logic [CFG_W-1:0]     frame_height_r;
  logic [CLW-1:0]       col_r, col_nxt;
  logic [ROW_CNT_W-1:0] row_r, row_nxt;
  logic [SAMPLE_W-1:0]  pending_r, pending_nxt;

  logic                 accept;
  logic [WW-1:0]        rw_ext, w_ext;
  logic [CW-1:0]        w;
  logic [CFG_W-1:0]     h;
  logic [CLW-1:0]       col_eff;
  logic [ROW_CNT_W-1:0] row_eff;
  logic [SAMPLE_W-1:0]  pending_eff;
  logic [CW-1:0]        col_x, pairs2, half_col, col_inc;
  logic [CFG_W-1:0]     row_x, rows2, row_inc;
  logic                 in_blk, wrap;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign accept       = in_ch.valid && push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= ROW_WIDTH_RESET;
      frame_height_r <= FRAME_HEIGHT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ROW_WIDTH:    row_width_r    <= cfg_ch.data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Effective geometry: width and height are held to their legal ranges.
  always_comb begin
    rw_ext = WW'(row_width_r);
    if (rw_ext < WW'(2)) begin
      w_ext = WW'(2);
    end else if (rw_ext > MAX_W) begin
      w_ext = MAX_W;
    end else begin
      w_ext = rw_ext;
    end
    w = w_ext[CW-1:0];
    if (frame_height_r < CFG_W'(2)) begin
      h = CFG_W'(2);
    end else if (frame_height_r > MAX_H) begin
      h = MAX_H;
    end else begin
      h = frame_height_r;
    end
  end

  always_comb begin
    col_eff     = in_ch.first_of_frame ? '0 : col_r;
    row_eff     = in_ch.first_of_frame ? '0 : row_r;
    pending_eff = in_ch.first_of_frame ? '0 : pending_r;

    col_x    = CW'(col_eff);
    row_x    = CFG_W'(row_eff);
    pairs2   = {w[CW-1:1], 1'b0};
    rows2    = {h[CFG_W-1:1], 1'b0};
    half_col = col_x >> 1;
    in_blk   = (col_x < pairs2) && (row_x < rows2);

    push_item.op   = row_eff[0] ? OP_EMIT : OP_STORE;
    push_item.pair = PAIR_W'(pending_eff) + PAIR_W'(in_ch.sample);
    push_item.eor  = half_col == ((w >> 1) - CW'(1));
    push_item.eof  = push_item.eor && (row_x == rows2 - CFG_W'(1));
    push_slot      = half_col[SW-1:0];

    // An even column only opens a pair; the odd column closes it.
    push_valid  = in_ch.valid && in_blk && col_eff[0];
    pending_nxt = (in_blk && !col_eff[0]) ? in_ch.sample : pending_eff;

    col_inc = col_x + CW'(1);
    wrap    = col_inc >= w;
    col_nxt = wrap ? '0 : col_inc[CLW-1:0];
    row_inc = wrap ? row_x + CFG_W'(1) : row_x;
    row_nxt = (row_inc >= h) ? '0 : row_inc[ROW_CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      pending_r <= '0;
    end else if (accept) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      pending_r <= pending_nxt;
    end
  end

`ifndef SYNTH
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(col_r) < MAX_ROW_WIDTH) else $error("column counter out of range");
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(row_r) < MAX_FRAME_HEIGHT) else $error("row counter out of range");
`endif

endmodule

/* rtl/bds_queue.sv */
`timescale 1ns / 1ps

module bds_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import bds_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign push_ready = count_r != NW'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slots_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(QUEUE_DEPTH)) else $error("queue count above depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + NW'(1)))
    else $error("queue count did not follow a push");
`endif

endmodule

/* rtl/bds_back.sv */
`timescale 1ns / 1ps

module bds_back #(
  parameter int MAX_ROW_WIDTH = bds_pkg::BDS_MAX_ROW_WIDTH,
  parameter int SW            = $clog2(MAX_ROW_WIDTH / 2)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  bds_pkg::bds_item_t   pop_item,
  input  logic [SW-1:0]        pop_slot,
  bds_out_if.source            out_ch
);
  import bds_pkg::*;

  localparam int DEPTH = MAX_ROW_WIDTH / 2;

  logic                 pop;
  logic                 ram_we, ram_re;
  logic [PAIR_W-1:0]    ram_rdata_r;

  logic                 s1_v_r;
  logic [PAIR_W-1:0]    s1_pair_r;
  logic                 s1_eor_r, s1_eof_r;
  logic                 s1_adv;

  logic                 out_v_r;
  logic [SAMPLE_W-1:0]  avg_r, avg_nxt;
  logic                 eor_r, eof_r;
  logic [PAIR_W:0]      sum;

  // The line store read data holds while the block stage is stalled,
  // since no new read is issued until it moves on.
  assign s1_adv    = s1_v_r && (!out_v_r || out_ch.ready);
  assign pop_ready = !s1_v_r || s1_adv;
  assign pop       = pop_valid && pop_ready;
  assign ram_we    = pop && (pop_item.op == OP_STORE);
  assign ram_re    = pop && (pop_item.op == OP_EMIT);

  bds_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .we      (ram_we),
    .re      (ram_re),
    .addr    (pop_slot),
    .wdata   (pop_item.pair),
    .rdata_r (ram_rdata_r)
  );

  assign sum     = (PAIR_W + 1)'(ram_rdata_r) + (PAIR_W + 1)'(s1_pair_r);
  assign avg_nxt = sum[PAIR_W:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (pop_ready) begin
        s1_v_r <= ram_re;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_pair_r <= pop_item.pair;
      s1_eor_r  <= pop_item.eor;
      s1_eof_r  <= pop_item.eof;
    end
    if (s1_adv) begin
      avg_r <= avg_nxt;
      eor_r <= s1_eor_r;
      eof_r <= s1_eof_r;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.average       = avg_r;
  assign out_ch.last_of_row   = eor_r;
  assign out_ch.last_of_frame = eof_r;

`ifndef SYNTH
  a_block_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_v_r) else $error("finished block did not reach the output");
  a_frame_implies_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && eof_r) |-> eor_r) else $error("frame end without row end");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import bds_pkg::*;

  localparam int STORE_DEPTH = BDS_MAX_ROW_WIDTH / 2;
  localparam int DRAIN_TAIL  = 8;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_PHASE  = 6;
  localparam int MAX_PRINTS  = 40;

  // An index that decodes to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(15);

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                last_of_row;
    logic                last_of_frame;
  } block_avg_t;

  typedef enum logic {
    STEP_CFG  = 1'b0,
    STEP_WORD = 1'b1
  } step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    logic [SAMPLE_W-1:0]  sample;
    logic                 first;
    logic                 typed;
    logic                 has_avg;
    block_avg_t           avg;
  } dir_step_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [11:0]      count;
    logic             noise;
    logic             quiet;
  } phase_t;

  localparam phase_t PHASES [9] = '{
    '{CFG_W'(6),    CFG_W'(4),    12'd120,  1'b1, 1'b0},
    '{CFG_W'(2047), CFG_W'(2),    12'd1060, 1'b0, 1'b0},
    '{CFG_W'(2),    CFG_W'(1024), 12'd100,  1'b1, 1'b0},
    '{CFG_W'(0),    CFG_W'(2047), 12'd40,   1'b1, 1'b0},
    '{CFG_W'(1),    CFG_W'(1),    12'd40,   1'b1, 1'b0},
    '{CFG_W'(7),    CFG_W'(5),    12'd140,  1'b1, 1'b0},
    '{CFG_W'(12),   CFG_W'(6),    12'd150,  1'b1, 1'b0},
    '{CFG_W'(2),    CFG_W'(2),    12'd60,   1'b1, 1'b0},
    '{CFG_W'(10),   CFG_W'(4),    12'd120,  1'b1, 1'b1}
  };

  logic clk;
  logic rst_n;

  bds_in_if  in_ch ();
  bds_out_if out_ch ();
  bds_cfg_if cfg_ch ();

  box_downsample_2x2_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Shadow copy of the block's state.
  logic [PAIR_W-1:0] pair_store [STORE_DEPTH];
  logic [PAIR_W-1:0] held_even;
  int unsigned       col_cnt;
  int unsigned       row_cnt;
  logic [CFG_W-1:0]  width_reg;
  logic [CFG_W-1:0]  height_reg;

  block_avg_t pending_avgs [$];
  int         fail_count = 0;
  bit         hold_request = 1'b0;
  bit         quiet = 1'b0;

  // These follow the input word, so they change only with nonblocking assignments.
  logic       typed_now;
  logic       typed_has;
  block_avg_t typed_avg;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] value,
                                            input int unsigned hi);
    if (value < 2) return 2;
    if (value > hi) return hi;
    return 32'(value);
  endfunction

  function automatic bit predict_average(input logic [SAMPLE_W-1:0] sample,
                                         input logic first, output block_avg_t avg);
    int unsigned     w;
    int unsigned     h;
    int unsigned     pairs;
    int unsigned     slot;
    logic [PAIR_W:0] sum;
    bit              produced;
    w = clamp_dim(width_reg, BDS_MAX_ROW_WIDTH);
    h = clamp_dim(height_reg, MAX_FRAME_HEIGHT);
    pairs = w / 2;
    produced = 1'b0;
    avg = '0;
    if (first) begin
      col_cnt = 0;
      row_cnt = 0;
      held_even = '0;
    end
    if (col_cnt < 2 * pairs && row_cnt < 2 * (h / 2)) begin
      slot = (col_cnt / 2) % STORE_DEPTH;
      if (col_cnt % 2 == 0) begin
        held_even = PAIR_W'(sample);
      end else if (row_cnt % 2 == 0) begin
        pair_store[slot] = held_even + PAIR_W'(sample);
      end else begin
        sum = {1'b0, pair_store[slot]} + {1'b0, held_even} + (PAIR_W + 1)'(sample);
        avg.average = sum[PAIR_W:2];
        avg.last_of_row = (col_cnt / 2) == pairs - 1;
        avg.last_of_frame = avg.last_of_row && row_cnt == 2 * (h / 2) - 1;
        produced = 1'b1;
      end
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
    if (row_cnt >= h) row_cnt = 0;
    return produced;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin : monitor
    block_avg_t model_avg;
    block_avg_t want;
    bit         model_has;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_ROW_WIDTH) width_reg = cfg_ch.data;
        else if (cfg_ch.index == REG_FRAME_HEIGHT) height_reg = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        model_has = predict_average(in_ch.sample, in_ch.first_of_frame, model_avg);
        if (typed_now) begin
          if (typed_has) pending_avgs.push_back(typed_avg);
        end else if (model_has) begin
          pending_avgs.push_back(model_avg);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_avgs.size() == 0) begin
          report_mismatch($sformatf("average %0d arrived with none outstanding",
                                    out_ch.average));
        end else begin
          want = pending_avgs.pop_front();
          if (out_ch.average !== want.average)
            report_mismatch($sformatf("average %0d, wanted %0d",
                                      out_ch.average, want.average));
          if (out_ch.last_of_row !== want.last_of_row)
            report_mismatch($sformatf("last_of_row %0b, wanted %0b",
                                      out_ch.last_of_row, want.last_of_row));
          if (out_ch.last_of_frame !== want.last_of_frame)
            report_mismatch($sformatf("last_of_frame %0b, wanted %0b",
                                      out_ch.last_of_frame, want.last_of_frame));
        end
      end
    end
  end

  initial begin : receiver
    int n;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [SAMPLE_W-1:0] sample, input logic first,
                           input logic typed, input logic has, input block_avg_t avg);
    in_ch.valid <= 1'b1;
    in_ch.sample <= sample;
    in_ch.first_of_frame <= first;
    typed_now <= typed;
    typed_has <= has;
    typed_avg <= avg;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause_input(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops the input and waits until every outstanding average has come out.
  task automatic drain_averages();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_avgs.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Leaves valid high so that back-to-back writes need no second assignment.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  function automatic dir_step_t cfg_step(input logic [CFG_IDX_W-1:0] index,
                                         input logic [CFG_W-1:0] data);
    return '{STEP_CFG, index, data, '0, 1'b0, 1'b0, 1'b0, '0};
  endfunction

  function automatic dir_step_t word_step(input logic [SAMPLE_W-1:0] sample,
                                          input logic first, input logic typed,
                                          input logic has, input logic [SAMPLE_W-1:0] average,
                                          input logic lor, input logic lof);
    return '{STEP_WORD, '0, '0, sample, first, typed, has, '{average, lor, lof}};
  endfunction

  initial begin : stimulus
    dir_step_t           steps [$];
    bit                  prev_cfg;
    int unsigned         frame_len;
    int unsigned         pos;
    int                  k;
    logic                first;
    logic [SAMPLE_W-1:0] sample;

    foreach (pair_store[i]) pair_store[i] = '0;
    held_even = '0;
    col_cnt = 0;
    row_cnt = 0;
    width_reg = ROW_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.first_of_frame <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_ROW_WIDTH;
    cfg_ch.data <= '0;
    typed_now <= 1'b0;
    typed_has <= 1'b0;
    typed_avg <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame: full scale, then a wrap without a frame flag, then an
    // early restart that must drop the half-built block.
    steps.push_back(cfg_step(REG_ROW_WIDTH, CFG_W'(2)));
    steps.push_back(cfg_step(REG_FRAME_HEIGHT, CFG_W'(2)));
    steps.push_back(word_step(16'hFFFF, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'hFFFF, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'hFFFF, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'hFFFF, 1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1));
    steps.push_back(word_step(16'd1, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd2, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd3, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd5, 1'b0, 1'b1, 1'b1, 16'd2, 1'b1, 1'b1));
    steps.push_back(word_step(16'd9, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd9, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd9, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd0, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd0, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd0, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd0, 1'b0, 1'b1, 1'b1, 16'd0, 1'b1, 1'b1));
    // Odd width and height: the last column and the last row are dropped.
    steps.push_back(cfg_step(REG_ROW_WIDTH, CFG_W'(3)));
    steps.push_back(cfg_step(REG_FRAME_HEIGHT, CFG_W'(3)));
    steps.push_back(word_step(16'd100, 1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd200, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'hFFFF, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd300, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd400, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'hFFFF, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd7, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd7, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(word_step(16'd7, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0));

    prev_cfg = 1'b0;
    foreach (steps[i]) begin
      if (steps[i].kind == STEP_CFG) begin
        if (!prev_cfg) drain_averages();
        write_register(steps[i].index, steps[i].data);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_ch.valid <= 1'b0;
        prev_cfg = 1'b0;
        if ($urandom_range(0, 5) == 0) pause_input($urandom_range(1, 19));
        send_word(steps[i].sample, steps[i].first, steps[i].typed, steps[i].has_avg,
                  steps[i].avg);
      end
    end

    foreach (PHASES[p]) begin
      drain_averages();
      quiet = PHASES[p].quiet;
      write_register(REG_ROW_WIDTH, PHASES[p].width);
      write_register(REG_FRAME_HEIGHT, PHASES[p].height);
      if (p == 0) write_register(REG_SPARE, CFG_W'($urandom));
      cfg_ch.valid <= 1'b0;
      frame_len = clamp_dim(PHASES[p].width, BDS_MAX_ROW_WIDTH) *
                  clamp_dim(PHASES[p].height, MAX_FRAME_HEIGHT);
      pos = 0;
      for (k = 0; k < int'(PHASES[p].count); k++) begin
        // Always restart after a setting change; otherwise flag some frame
        // starts and, rarely, break a frame with a restart in the middle.
        first = (k == 0);
        if (pos == 0 && $urandom_range(0, 1) == 1) first = 1'b1;
        if (PHASES[p].noise && $urandom_range(0, 99) == 0) first = 1'b1;
        if (first) pos = 0;
        if (p == HOLD_PHASE && k == 20) hold_request = 1'b1;
        if (p == HOLD_PHASE && k == 90) drain_averages();
        if (!quiet && $urandom_range(0, 7) == 0) pause_input($urandom_range(1, 19));
        case ($urandom_range(0, 7))
          0: sample = '0;
          1: sample = '1;
          default: sample = SAMPLE_W'($urandom);
        endcase
        send_word(sample, first, 1'b0, 1'b0, '0);
        pos = (pos + 1) % frame_len;
      end
    end

    drain_averages();
    if (fail_count == 0) begin
      $display("box_downsample_2x2_top: match");
    end else begin
      $display("box_downsample_2x2_top: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("box_downsample_2x2_top: mismatch");
    $finish;
  end

endmodule
